// File: design/rpwc_pkg.sv
// rpwc_pkg: shared types and constants of the rc pulse width capture block
// used by the channel interfaces, the channel store, the serial divider and the top level
// no dependencies
package rpwc_pkg;

    // fixed field widths
    localparam int ChanW    = 2;
    localparam int TsW      = 32;
    localparam int ValueW   = 15;
    localparam int PctW     = 8;
    localparam int CfgW     = 12;
    localparam int CfgIdxW  = 2;

    // pulse validity window and scaling, microseconds
    localparam int MinValidUs = 500;
    localparam int MaxValidUs = 2500;
    localparam int CentreUs   = 1500;
    localparam int PwmMinRst  = 1000;
    localparam int PwmMaxRst  = 2000;
    localparam int FullScale  = 100;

    // dividend of the percent division: 12 bit magnitude times 100
    localparam int NumW = 19;
    localparam int CntW = $clog2(NumW);

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_OVERRIDE = 2'd0,
        CFG_PWM_MIN  = 2'd1,
        CFG_PWM_MID  = 2'd2,
        CFG_PWM_MAX  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } t_state;

    // command from the control fsm to the channel store
    typedef struct packed {
        logic              edge_en;
        logic              ovr_en;
        logic [ChanW-1:0]  channel;
        logic              level;
        logic [TsW-1:0]    timestamp;
        logic [ValueW-1:0] value;
    } t_store_cmd;

    // lookup results from the channel store
    typedef struct packed {
        logic              ch_ok;
        logic [CfgW-1:0]   edge_width;
        logic              updated;
        logic [ValueW-1:0] read_width;
    } t_store_rsp;

endpackage

// File: design/rpwc_ifs.sv
// rpwc_req_if and rpwc_rsp_if: valid/ready channels of the pulse width capture block
// depends on rpwc_pkg
interface rpwc_req_if import rpwc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ChanW-1:0]  channel;
    logic              level;
    logic [TsW-1:0]    timestamp;
    logic [ValueW-1:0] value;

    modport source (output valid, req_type, channel, level, timestamp, value, input ready);
    modport sink   (input valid, req_type, channel, level, timestamp, value, output ready);
endinterface

interface rpwc_rsp_if import rpwc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ChanW-1:0]       out_channel;
    logic [ValueW-1:0]      raw_width;
    logic signed [PctW-1:0] percent;
    logic                   width_updated;

    modport source (output valid, out_channel, raw_width, percent, width_updated, input ready);
    modport sink   (input valid, out_channel, raw_width, percent, width_updated, output ready);
endinterface

// File: design/rpwc_chan_store.sv
// rpwc_chan_store: per-channel rise times and measured widths, override widths for channels 0 and 1
// depends on rpwc_pkg
module rpwc_chan_store import rpwc_pkg::*; #(
    parameter int CHAN_COUNT = 4,
    parameter int TIME_BITS  = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_store_cmd      i_cmd,
    input  logic            i_override_enable,
    input  logic [CfgW-1:0] i_pwm_mid,
    output t_store_rsp      o_rsp
);

    localparam int ChIdxW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

    logic [TIME_BITS-1:0] r_rise_time [CHAN_COUNT];
    logic                 r_rise_seen [CHAN_COUNT];
    logic [CfgW-1:0]      r_meas      [CHAN_COUNT];
    logic [ValueW-1:0]    r_ovr       [2];

    logic                 w_ch_ok;
    logic                 w_ovr_ch;
    logic [ChIdxW-1:0]    w_idx;
    logic [TIME_BITS-1:0] w_ts;
    logic [TIME_BITS-1:0] w_diff;
    logic                 w_in_range;
    logic [CfgW-1:0]      w_meas_next;
    logic                 w_fall_done;

    // channel decode and wrapping time difference
    assign w_ch_ok    = 32'(i_cmd.channel) < CHAN_COUNT;
    assign w_ovr_ch   = i_cmd.channel < ChanW'(2);
    assign w_idx      = ChIdxW'(i_cmd.channel);
    assign w_ts       = TIME_BITS'(i_cmd.timestamp);
    assign w_diff     = w_ts - r_rise_time[w_idx];
    assign w_in_range = (w_diff >= TIME_BITS'(MinValidUs)) && (w_diff <= TIME_BITS'(MaxValidUs));
    assign w_meas_next = w_in_range ? CfgW'(w_diff) : i_pwm_mid;
    assign w_fall_done = w_ch_ok && !i_cmd.level && r_rise_seen[w_idx];

    // lookup results for the item on the input
    always_comb begin
        o_rsp.ch_ok      = w_ch_ok;
        o_rsp.updated    = w_fall_done;
        o_rsp.edge_width = '0;
        o_rsp.read_width = '0;
        if (w_ch_ok) begin
            o_rsp.edge_width = w_fall_done ? w_meas_next : r_meas[w_idx];
            if (i_override_enable && w_ovr_ch) begin
                o_rsp.read_width = r_ovr[i_cmd.channel[0]];
            end else begin
                o_rsp.read_width = ValueW'(r_meas[w_idx]);
            end
        end
    end

    // edge updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                r_rise_time[i] <= '0;
                r_rise_seen[i] <= 1'b0;
                r_meas[i]      <= CfgW'(CentreUs);
            end
        end else if (i_cmd.edge_en && w_ch_ok) begin
            if (i_cmd.level) begin
                r_rise_time[w_idx] <= w_ts;
                r_rise_seen[w_idx] <= 1'b1;
            end else if (r_rise_seen[w_idx]) begin
                r_meas[w_idx]      <= w_meas_next;
                r_rise_seen[w_idx] <= 1'b0;
            end
        end
    end

    // override width writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr[0] <= ValueW'(CentreUs);
            r_ovr[1] <= ValueW'(CentreUs);
        end else if (i_cmd.ovr_en && w_ovr_ch) begin
            r_ovr[i_cmd.channel[0]] <= i_cmd.value;
        end
    end

endmodule

// File: design/rpwc_serial_div.sv
// rpwc_serial_div: restoring divider, one quotient bit per cycle
// depends on rpwc_pkg
module rpwc_serial_div import rpwc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NumW-1:0] i_num,
    input  logic [CfgW-1:0] i_den,
    output logic            o_done,
    output logic [NumW-1:0] o_quot
);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [CfgW-1:0] r_den;
    logic [CfgW-1:0] r_rem;
    logic [NumW-1:0] r_quot;

    logic [CfgW:0]   w_rem_sh;
    logic            w_ge;
    logic [CfgW:0]   w_rem_sub;

    // shift in the next dividend bit and trial-subtract
    assign w_rem_sh  = {r_rem, r_quot[NumW-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(NumW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out of r_quot while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= w_ge ? CfgW'(w_rem_sub) : CfgW'(w_rem_sh);
            r_quot <= {r_quot[NumW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: design/rc_pulse_width_capture_core.sv
// rc_pulse_width_capture_core: top level of the rc servo pulse width capture block
// depends on rpwc_pkg, rpwc_ifs, rpwc_chan_store and rpwc_serial_div
//
// usage
//   i_req carries edge, read and override write requests; o_rsp carries one result
//   per edge or read request. write and unused request types give no result.
//   configuration (override enable, pwm min/mid/max) goes through a plain write
//   port: i_cfg_we, i_cfg_idx, i_cfg_data; write it only while the block is idle.
// sequence
//   an edge request is captured into the pending result on accept, and the emit state
//   then loads it into the output register; the next request is accepted only once
//   the fsm is back in idle. a read request is captured on accept; the prep state
//   clamps and scales the width and loads it into the bit-serial restoring divider;
//   when the divider is done, the percent is saturated, signed and held in the
//   pending result, and the emit state then loads the output register.
//   reads of a missing channel or with pwm_max <= pwm_mid skip the divider and
//   go from the prep state straight to the emit state.
//   one request is in flight at a time; i_req.ready is high while the fsm is idle.
// reset
//   synchronous active-low; channel widths and override widths return to 1500,
//   rise marks clear and the configuration returns to 0/1000/1500/2000.
// stall
//   the output register holds a result until taken; the next request is accepted
//   and worked on meanwhile, and its result waits until the output register frees.
module rc_pulse_width_capture_core import rpwc_pkg::*; #(
    parameter int CHAN_COUNT = 4,
    parameter int TIME_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rpwc_req_if.sink           i_req,
    rpwc_rsp_if.source         o_rsp,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data
);

    // configuration registers
    logic            r_override_enable;
    logic [CfgW-1:0] r_pwm_min;
    logic [CfgW-1:0] r_pwm_mid;
    logic [CfgW-1:0] r_pwm_max;

    // fsm and pending result
    t_state                 r_state;
    t_state                 n_state;
    logic                   r_ch_ok;
    logic [ChanW-1:0]       r_res_chan;
    logic [ValueW-1:0]      r_res_raw;
    logic signed [PctW-1:0] r_res_pct;
    logic                   r_res_upd;
    logic                   r_neg;

    // output register
    logic                   r_out_valid;
    logic [ChanW-1:0]       r_out_chan;
    logic [ValueW-1:0]      r_out_raw;
    logic signed [PctW-1:0] r_out_pct;
    logic                   r_out_upd;

    t_req_type       w_req_type;
    logic            w_accept;
    logic            w_out_free;
    logic            w_ready;
    logic            w_div_start;
    logic            w_load_out;
    t_store_cmd      w_cmd;
    t_store_rsp      w_srsp;
    logic            w_div_done;
    logic [NumW-1:0] w_quot;

    // prep stage arithmetic
    logic [ValueW-1:0] w_clamp_lo;
    logic [ValueW-1:0] w_clamp_hi;
    logic [CfgW:0]     w_delta;
    logic [CfgW-1:0]   w_mag;
    logic [NumW-1:0]   w_num;
    logic [CfgW-1:0]   w_den;
    logic              w_scale_ok;
    logic [PctW-2:0]   w_sat;

    assign w_req_type = t_req_type'(i_req.req_type);
    assign w_accept   = i_req.valid && w_ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override_enable <= 1'b0;
            r_pwm_min         <= CfgW'(PwmMinRst);
            r_pwm_mid         <= CfgW'(CentreUs);
            r_pwm_max         <= CfgW'(PwmMaxRst);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OVERRIDE: r_override_enable <= i_cfg_data[0];
                CFG_PWM_MIN:  r_pwm_min <= i_cfg_data;
                CFG_PWM_MID:  r_pwm_mid <= i_cfg_data;
                CFG_PWM_MAX:  r_pwm_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel store command
    always_comb begin
        w_cmd.edge_en   = w_accept && (w_req_type == REQ_EDGE);
        w_cmd.ovr_en    = w_accept && (w_req_type == REQ_WRITE);
        w_cmd.channel   = i_req.channel;
        w_cmd.level     = i_req.level;
        w_cmd.timestamp = i_req.timestamp;
        w_cmd.value     = i_req.value;
    end

    rpwc_chan_store #(
        .CHAN_COUNT (CHAN_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_store (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_override_enable (r_override_enable),
        .i_pwm_mid         (r_pwm_mid),
        .o_rsp             (w_srsp)
    );

    // clamp to min then max, signed offset from mid, scale by 100
    assign w_clamp_lo = (r_res_raw < ValueW'(r_pwm_min)) ? ValueW'(r_pwm_min) : r_res_raw;
    assign w_clamp_hi = (w_clamp_lo > ValueW'(r_pwm_max)) ? ValueW'(r_pwm_max) : w_clamp_lo;
    assign w_delta    = {1'b0, CfgW'(w_clamp_hi)} - {1'b0, r_pwm_mid};
    assign w_mag      = w_delta[CfgW] ? CfgW'(-w_delta) : CfgW'(w_delta);
    assign w_num      = NumW'(w_mag) * NumW'(FullScale);
    assign w_den      = r_pwm_max - r_pwm_mid;
    assign w_scale_ok = r_ch_ok && (r_pwm_max > r_pwm_mid);

    rpwc_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // saturate the quotient at full scale
    assign w_sat = (w_quot > NumW'(FullScale)) ? (PctW-1)'(FullScale) : (PctW-1)'(w_quot);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_req_type == REQ_EDGE) begin
                        n_state = ST_EMIT;
                    end else if (w_req_type == REQ_READ) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: n_state = w_scale_ok ? ST_DIV : ST_EMIT;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        w_ready     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: w_ready     = 1'b1;
            ST_PREP: w_div_start = w_scale_ok;
            ST_DIV:  ;
            ST_EMIT: w_load_out  = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pending result capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_res_chan <= i_req.channel;
            r_ch_ok    <= w_srsp.ch_ok;
            r_res_pct  <= '0;
            if (w_req_type == REQ_EDGE) begin
                r_res_raw <= ValueW'(w_srsp.edge_width);
                r_res_upd <= w_srsp.updated;
            end else begin
                r_res_raw <= w_srsp.read_width;
                r_res_upd <= 1'b0;
            end
        end else if (r_state == ST_PREP) begin
            r_neg <= w_delta[CfgW];
        end else if (r_state == ST_DIV && w_div_done) begin
            r_res_pct <= r_neg ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_chan <= r_res_chan;
            r_out_raw  <= r_res_raw;
            r_out_pct  <= r_res_pct;
            r_out_upd  <= r_res_upd;
        end
    end

    assign i_req.ready         = w_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.out_channel   = r_out_chan;
    assign o_rsp.raw_width     = r_out_raw;
    assign o_rsp.percent       = r_out_pct;
    assign o_rsp.width_updated = r_out_upd;

endmodule
